[src/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types of the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int IDX_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NUM_W       = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W       = 4;
  localparam int CFG_RESET   = 3;
  localparam int PAGE_W      = 4;
  localparam int FRAME_W     = 3;
  localparam int COUNT_WIDTH = 16;
  localparam int TIME_W      = 32;
  localparam int FAULT_W     = 16;

  typedef struct packed {
    logic                   vld;
    logic                   hit_found;
    logic [IDX_W-1:0]       hit_idx;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   min_found;
    logic [IDX_W-1:0]       min_idx;
    logic [COUNT_WIDTH-1:0] min_cnt;
    logic [TIME_W-1:0]      min_time;
    logic [PAGE_W-1:0]      min_page;
  } lfu_rec_t;

  typedef struct packed {
    logic              clr;
    logic              en;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] page;
    logic [TIME_W-1:0] ltime;
  } lfu_upd_t;

endpackage

[src/lfu_if.sv]
// ----------------------------------------------------------------------------
// lfu_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lfu_in_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              start_of_string;

  modport source (output valid, page, start_of_string, input ready);
  modport sink   (input valid, page, start_of_string, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, hit, frame, evicted_valid, evicted_page, fault_total,
                  input ready);
  modport sink   (input valid, hit, frame, evicted_valid, evicted_page, fault_total,
                  output ready);
endinterface

[src/lfu_cell.sv]
// ----------------------------------------------------------------------------
// lfu_cell
// One frame of the replacement chain: holds its page, use count and load
// time, and folds them into the search record passed to its neighbor.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [NUM_W-1:0]  active_n,
  input  logic [PAGE_W-1:0] page,
  input  lfu_upd_t          upd,
  input  lfu_rec_t          rec_i,
  output lfu_rec_t          rec_o
);

  logic                   valid_r;
  logic [PAGE_W-1:0]      page_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [TIME_W-1:0]      time_r;
  lfu_rec_t               rec_r;
  lfu_rec_t               rec_nxt;
  logic                   act;
  logic                   better;
  logic                   mine;

  assign act    = 32'(cell_idx) < 32'(active_n);
  assign better = !rec_i.min_found || (cnt_r < rec_i.min_cnt) ||
                  ((cnt_r == rec_i.min_cnt) && (time_r < rec_i.min_time));
  assign mine   = upd.en && (upd.idx == cell_idx);

  always_comb begin
    rec_nxt = rec_i;
    if (act && valid_r && (page_r == page) && !rec_i.hit_found) begin
      rec_nxt.hit_found = 1'b1;
      rec_nxt.hit_idx   = cell_idx;
    end
    if (act && !valid_r && !rec_i.free_found) begin
      rec_nxt.free_found = 1'b1;
      rec_nxt.free_idx   = cell_idx;
    end
    if (act && valid_r && better) begin
      rec_nxt.min_found = 1'b1;
      rec_nxt.min_idx   = cell_idx;
      rec_nxt.min_cnt   = cnt_r;
      rec_nxt.min_time  = time_r;
      rec_nxt.min_page  = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      rec_r.vld <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
      if (upd.clr) begin
        valid_r <= 1'b0;
      end else if (mine && !upd.hit) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mine) begin
      if (upd.hit) begin
        if (cnt_r != {COUNT_WIDTH{1'b1}}) begin
          cnt_r <= cnt_r + COUNT_WIDTH'(1);
        end
      end else begin
        page_r <= upd.page;
        cnt_r  <= COUNT_WIDTH'(1);
        time_r <= upd.ltime;
      end
    end
  end

  assign rec_o = rec_r;

endmodule

[src/lfu_page_replacement.sv]
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement with first-loaded tie break over a chain of frame cells.
// ----------------------------------------------------------------------------
// The input channel carries one page reference per beat; the result channel
// returns one beat per reference with hit, frame, evicted page and the fault
// total. The cfg_ port writes the number of managed frames.
// After a reference is accepted, a search record walks the frame cells, one
// cell per cycle, and collects the matching frame, the lowest empty frame and
// the least used frame. The record waits at the end of the chain; the chosen
// frame is updated when the result is registered, once the output is free.
// The time from acceptance to a result is set by the walk along the chain;
// a new reference is accepted once the previous result is registered.
// Reset empties all frames, clears the fault total and the reference index,
// and sets the frame count to three. A start flag on a reference does the
// same clearing, the frame count aside. While the receiver stalls, the
// result is held in the output register, the next reference is still taken,
// and its search waits in front of the output register until it frees up.
// ----------------------------------------------------------------------------
module lfu_page_replacement import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  lfu_in_if.sink           in_ch,
  lfu_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]   cfg_r;
  logic [NUM_W-1:0]   active_n;
  logic               busy_r;
  logic               launch_r;
  logic [PAGE_W-1:0]  page_r;
  lfu_rec_t           res_r;
  logic               pend_r;
  logic [TIME_W-1:0]  ref_idx_r;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_ev_valid_r;
  logic [PAGE_W-1:0]  out_ev_page_r;
  logic [FAULT_W-1:0] out_fault_r;
  logic               accept;
  logic               commit;
  logic [IDX_W-1:0]   sel;
  logic               evict;
  lfu_upd_t           upd;
  lfu_rec_t           seed;
  lfu_rec_t           rec [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] tok;

  always_comb begin
    if (cfg_r == '0) begin
      active_n = NUM_W'(1);
    end else if (32'(cfg_r) > MAX_FRAMES) begin
      active_n = NUM_W'(MAX_FRAMES);
    end else begin
      active_n = NUM_W'(cfg_r);
    end
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign commit = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy_r;

  always_comb begin
    priority if (res_r.hit_found) begin
      sel = res_r.hit_idx;
    end else if (res_r.free_found) begin
      sel = res_r.free_idx;
    end else begin
      sel = res_r.min_idx;
    end
  end

  assign evict     = !res_r.hit_found && !res_r.free_found;
  assign fault_nxt = (!res_r.hit_found && (fault_r != {FAULT_W{1'b1}})) ?
                     fault_r + FAULT_W'(1) : fault_r;

  always_comb begin
    upd.clr   = accept && in_ch.start_of_string;
    upd.en    = commit;
    upd.hit   = res_r.hit_found;
    upd.idx   = sel;
    upd.page  = page_r;
    upd.ltime = ref_idx_r;
  end

  always_comb begin
    seed     = '0;
    seed.vld = launch_r;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .active_n (active_n),
      .page     (page_r),
      .upd      (upd),
      .rec_i    ((g == 0) ? seed : rec[(g == 0) ? 0 : g - 1]),
      .rec_o    (rec[g])
    );
    assign tok[g] = rec[g].vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(CFG_RESET);
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      pend_r      <= 1'b0;
      ref_idx_r   <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      launch_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
        if (in_ch.start_of_string) begin
          ref_idx_r <= '0;
          fault_r   <= '0;
        end
      end else if (commit) begin
        busy_r <= 1'b0;
      end
      if (rec[MAX_FRAMES-1].vld) begin
        pend_r <= 1'b1;
      end else if (commit) begin
        pend_r <= 1'b0;
      end
      if (commit) begin
        fault_r <= fault_nxt;
        if (ref_idx_r != {TIME_W{1'b1}}) begin
          ref_idx_r <= ref_idx_r + TIME_W'(1);
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= in_ch.page;
    end
    if (rec[MAX_FRAMES-1].vld) begin
      res_r <= rec[MAX_FRAMES-1];
    end
    if (commit) begin
      out_hit_r      <= res_r.hit_found;
      out_frame_r    <= FRAME_W'(sel);
      out_ev_valid_r <= evict;
      out_ev_page_r  <= evict ? res_r.min_page : '0;
      out_fault_r    <= fault_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame         = out_frame_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.fault_total   = out_fault_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok, pend_r, launch_r}))
    else $error("more than one reference in flight");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (tok == '0) && !pend_r && !launch_r)
    else $error("input ready while a search is under way");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.evicted_valid))
    else $error("eviction reported on a hit");

  a_commit_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !busy_r && out_ch.valid)
    else $error("commit did not release the block");

endmodule
